@@ rtl/core/arcrf_pkg.sv @@
// Shared types and constants of the ARC ALU and register file block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package arcrf_pkg;

   localparam int unsigned IDX_W  = 6;
   localparam int unsigned DATA_W = 32;

   // Item kinds on the request side; code 3 is unused.
   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_ALU   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      OP_ANDCC    = 4'd0,
      OP_ORCC     = 4'd1,
      OP_NORCC    = 4'd2,
      OP_ADDCC    = 4'd3,
      OP_SRL      = 4'd4,
      OP_AND      = 4'd5,
      OP_OR       = 4'd6,
      OP_NOR      = 4'd7,
      OP_ADD      = 4'd8,
      OP_LSHIFT2  = 4'd9,
      OP_LSHIFT10 = 4'd10,
      OP_SIMM13   = 4'd11,
      OP_SEXT13   = 4'd12,
      OP_INC      = 4'd13,
      OP_INCPC    = 4'd14,
      OP_RSHIFT5  = 4'd15
   } alu_op_type;

   localparam logic [31:0] SIMM13_MASK = 32'h00001FFF;
   localparam logic [31:0] SEXT13_FILL = 32'hFFFFE000;
   localparam logic [31:0] SIGN13_BIT  = 32'h00001000;
   localparam logic [31:0] RSHIFT_FILL = 32'hF8000000;
   localparam logic [31:0] PC_STEP     = 32'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request, start the register access
      logic execute;   // compute the result, load the output register
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/arc_alu_register_file_unit.sv @@
// Top level of the ARC ALU and register file block.
// Depends on arcrf_pkg, arcrf_ctrl, arcrf_dp (and arcrf_ram below it).
//
// Usage:
//   Request channel (req_*): one item per handshake. req_tuser carries the kind
//   (read, write, ALU operation); req_tdata carries register index, operand A,
//   operand B and ALU opcode. A write stores operand A; register zero reads zero.
//   Response channel (rsp_*): exactly one item per request. rsp_tuser is the ok
//   bit; rsp_tdata holds the result word, the N/Z/V/C flags after the item and
//   bit 12 of the instruction register.
//   Steps: the capture step latches a taken request and addresses the register
//   RAM, whose read port is registered; the execute step computes the result and
//   loads the output register behind rsp_tvalid, then the block takes requests again.
//   The next request is taken while the previous result still waits in the
//   output register; if the receiver stalls, the following item holds in the
//   execute step and req_tready stays low until the output register frees.
//   Reset: synchronous, active high. Flags, instruction register bit and the
//   per-register valid bits clear at once, so every register reads zero until
//   written; the block takes requests in the first cycle after reset.
`default_nettype none

module arc_alu_register_file_unit
   import arcrf_pkg::*;
#(
   parameter int unsigned NUM_REGS = 38,
   parameter int unsigned IR_INDEX = 37
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [5:0] reg_index, [37:6] operand_a, [69:38] operand_b, [73:70] alu_op, [79:74] zero
   input  wire logic [79:0] req_tdata,
   // [1:0] kind
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] data, [32] flag_n, [33] flag_z, [34] flag_v, [35] flag_c,
   // [36] ir_bit12, [39:37] zero
   output logic [39:0]      rsp_tdata,
   // [0] ok
   output logic             rsp_tuser
);

   cmd_type cmd;

   logic [DATA_W-1:0] data;
   logic ok, flag_n, flag_z, flag_v, flag_c, ir_bit12;

   // Sequence capture and execute, own the response valid.
   arcrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd)
   );

   // Hold the register file, flags and output register.
   arcrf_dp #(
      .NUM_REGS(NUM_REGS),
      .IR_INDEX(IR_INDEX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_kind     (req_tuser),
      .in_reg_index(req_tdata[5:0]),
      .in_operand_a(req_tdata[37:6]),
      .in_operand_b(req_tdata[69:38]),
      .in_alu_op   (req_tdata[73:70]),
      .out_data    (data),
      .out_ok      (ok),
      .out_flag_n  (flag_n),
      .out_flag_z  (flag_z),
      .out_flag_v  (flag_v),
      .out_flag_c  (flag_c),
      .out_ir_bit12(ir_bit12)
   );

   // Pack the response, pad to whole bytes.
   assign rsp_tdata = {3'b000, ir_bit12, flag_c, flag_v, flag_z, flag_n, data};
   assign rsp_tuser = ok;

endmodule

`default_nettype wire

@@ rtl/core/arcrf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module arcrf_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/arcrf_ctrl.sv @@
// Controller of the ARC ALU and register file: sequences capture and execute,
// owns the output valid flag. Depends on arcrf_pkg.
`default_nettype none

module arcrf_ctrl
   import arcrf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      cmd.capture = req_tvalid && req_tready;
      cmd.execute = (state_ff == ST_EXEC) && (!out_valid_ff || rsp_tready);

      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.execute) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      priority if (cmd.execute) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

@@ rtl/core/arcrf_dp.sv @@
// Datapath of the ARC ALU and register file: request latch, register RAM with
// per-entry valid bits, flags, ALU and output register. Depends on arcrf_pkg, arcrf_ram.
`default_nettype none

module arcrf_dp
   import arcrf_pkg::*;
#(
   parameter int unsigned NUM_REGS = 38,
   parameter int unsigned IR_INDEX = 37
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [1:0]         in_kind,
   input  wire logic [IDX_W-1:0]   in_reg_index,
   input  wire logic [DATA_W-1:0]  in_operand_a,
   input  wire logic [DATA_W-1:0]  in_operand_b,
   input  wire logic [3:0]         in_alu_op,
   output logic      [DATA_W-1:0]  out_data,
   output logic                    out_ok,
   output logic                    out_flag_n,
   output logic                    out_flag_z,
   output logic                    out_flag_v,
   output logic                    out_flag_c,
   output logic                    out_ir_bit12
);

   localparam int unsigned AW     = $clog2(NUM_REGS);
   localparam logic        HAS_IR = (IR_INDEX < NUM_REGS) && (IR_INDEX != 0);
   localparam logic [IDX_W-1:0] IR_IDX = IDX_W'(IR_INDEX);
   localparam logic [IDX_W:0]   NREGS  = (IDX_W + 1)'(NUM_REGS);

   // Latched request
   logic [1:0]        kind_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DATA_W-1:0] a_ff, b_ff;
   alu_op_type        op_ff;

   logic                in_idx_ok, idx_ok;
   logic                ram_we, ram_re;
   logic [DATA_W-1:0]   ram_rd;
   logic [NUM_REGS-1:0] valid_ff, valid_in;
   logic                ir_ff, ir_in;

   logic n_ff, z_ff, v_ff, c_ff;
   logic n_in, z_in, v_in, c_in;

   logic [DATA_W-1:0] alu_res, res;
   logic [DATA_W:0]   sum;
   logic              res_ok;

   logic [DATA_W-1:0] data_ff;
   logic              ok_ff, n_out_ff, z_out_ff, v_out_ff, c_out_ff, ir_out_ff;

   assign in_idx_ok = ({1'b0, in_reg_index} < NREGS);
   assign idx_ok    = ({1'b0, idx_ff} < NREGS);

   // Writes land at capture time; register zero is never stored.
   assign ram_we = cmd.capture && (in_kind == KIND_WRITE) && in_idx_ok
                   && (in_reg_index != '0);
   assign ram_re = cmd.capture && (in_kind == KIND_READ) && in_idx_ok;

   arcrf_ram #(
      .WIDTH(DATA_W),
      .DEPTH(NUM_REGS)
   ) u_regs (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(in_reg_index[AW-1:0]),
      .wr_data(in_operand_a),
      .rd_en  (ram_re),
      .rd_addr(in_reg_index[AW-1:0]),
      .rd_data(ram_rd)
   );

   always_comb begin
      valid_in = valid_ff;
      ir_in    = ir_ff;
      if (ram_we) begin
         valid_in[in_reg_index[AW-1:0]] = 1'b1;
         if (HAS_IR && (in_reg_index == IR_IDX)) begin
            ir_in = in_operand_a[12];
         end
      end
   end

   always_comb begin
      sum     = {1'b0, a_ff} + {1'b0, b_ff};
      alu_res = '0;
      n_in    = n_ff;
      z_in    = z_ff;
      v_in    = v_ff;
      c_in    = c_ff;
      unique case (op_ff)
         OP_ANDCC:    alu_res = a_ff & b_ff;
         OP_ORCC:     alu_res = a_ff | b_ff;
         OP_NORCC:    alu_res = ~(a_ff | b_ff);
         OP_ADDCC:    alu_res = sum[DATA_W-1:0];
         OP_SRL:      alu_res = a_ff >> b_ff[4:0];
         OP_AND:      alu_res = a_ff & b_ff;
         OP_OR:       alu_res = a_ff | b_ff;
         OP_NOR:      alu_res = ~(a_ff | b_ff);
         OP_ADD:      alu_res = sum[DATA_W-1:0];
         OP_LSHIFT2:  alu_res = a_ff << 2;
         OP_LSHIFT10: alu_res = a_ff << 10;
         OP_SIMM13:   alu_res = a_ff & SIMM13_MASK;
         OP_SEXT13: begin
            alu_res = a_ff & SIMM13_MASK;
            if ((a_ff & SIGN13_BIT) != '0) begin
               alu_res = alu_res | SEXT13_FILL;
            end
         end
         OP_INC:      alu_res = a_ff + 32'd1;
         OP_INCPC:    alu_res = a_ff + PC_STEP;
         OP_RSHIFT5: begin
            alu_res = a_ff >> 5;
            if (a_ff[31]) begin
               alu_res = alu_res | RSHIFT_FILL;
            end
         end
         default:     alu_res = '0;
      endcase

      res    = '0;
      res_ok = 1'b0;
      unique case (kind_ff)
         KIND_READ: begin
            if (idx_ok) begin
               res_ok = 1'b1;
               if (valid_ff[idx_ff[AW-1:0]]) begin
                  res = ram_rd;
               end
            end
         end
         KIND_WRITE: res_ok = idx_ok;
         KIND_ALU: begin
            res    = alu_res;
            res_ok = 1'b1;
            if ((op_ff == OP_ANDCC) || (op_ff == OP_ORCC) || (op_ff == OP_NORCC)) begin
               n_in = alu_res[31];
               z_in = (alu_res == '0);
               v_in = 1'b0;
               c_in = 1'b0;
            end else if (op_ff == OP_ADDCC) begin
               n_in = alu_res[31];
               z_in = (alu_res == '0);
               v_in = (a_ff[31] == b_ff[31]) && (alu_res[31] != a_ff[31]);
               c_in = sum[DATA_W];
            end
         end
         default: begin
            res    = '0;
            res_ok = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= in_kind;
         idx_ff  <= in_reg_index;
         a_ff    <= in_operand_a;
         b_ff    <= in_operand_b;
         op_ff   <= alu_op_type'(in_alu_op);
      end
      if (cmd.execute) begin
         data_ff   <= res;
         ok_ff     <= res_ok;
         n_out_ff  <= n_in;
         z_out_ff  <= z_in;
         v_out_ff  <= v_in;
         c_out_ff  <= c_in;
         ir_out_ff <= ir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ir_ff    <= 1'b0;
         n_ff     <= 1'b0;
         z_ff     <= 1'b0;
         v_ff     <= 1'b0;
         c_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ir_ff    <= ir_in;
         if (cmd.execute) begin
            n_ff <= n_in;
            z_ff <= z_in;
            v_ff <= v_in;
            c_ff <= c_in;
         end
      end
   end

   assign out_data     = data_ff;
   assign out_ok       = ok_ff;
   assign out_flag_n   = n_out_ff;
   assign out_flag_z   = z_out_ff;
   assign out_flag_v   = v_out_ff;
   assign out_flag_c   = c_out_ff;
   assign out_ir_bit12 = ir_out_ff;

endmodule

`default_nettype wire

@@ rtl/core/arcrf_checker.sv @@
// Port-level checks of arc_alu_register_file_unit, bound to the top level.
// No package dependencies.
`default_nettype none

module arcrf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // A stalled response holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // One item in execution at a time: a taken request drops ready next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A rejected item carries a zero word.
   a_not_ok_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("nonzero data with ok low");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind arc_alu_register_file_unit arcrf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
